// ===== sv/bpht_pkg.sv =====
// ----------------------------------------------------------------------------
// bpht_pkg
// Shared constants, record types, command codes and helpers for the
// bucketed position hash table.
// ----------------------------------------------------------------------------
package bpht_pkg;

  // table geometry
  localparam int unsigned SET_BITS    = 14;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned DEPTH_LIMIT = 127;
  localparam int unsigned NUM_SETS    = 1 << SET_BITS;
  localparam int unsigned WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;

  // score limits
  localparam int SCORE_MAX = 32767;
  localparam logic [14:0] THR_RESET = 15'd30000;

  // command codes
  localparam logic [2:0] CMD_SAVE  = 3'd0;
  localparam logic [2:0] CMD_PROBE = 3'd1;
  localparam logic [2:0] CMD_MOVE  = 3'd2;
  localparam logic [2:0] CMD_SING  = 3'd3;
  localparam logic [2:0] CMD_AGE   = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;

  // bound codes
  localparam logic [1:0] BND_UPPER = 2'd0;
  localparam logic [1:0] BND_LOWER = 2'd1;
  localparam logic [1:0] BND_EXACT = 2'd2;

  // one way of a set
  typedef struct packed {
    logic [31:0]        tag;
    logic [31:0]        mv;
    logic signed [15:0] val;
    logic [15:0]        age;
    logic signed [7:0]  dep;
    logic [1:0]         bnd;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
    logic clear_step;
  } dp_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic is_clear;
    logic clr_last;
  } dp_stat_t;

  // saturate a widened score to the symmetric 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sd32767;
    end else if (v < -18'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/bpht_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpht_ctrl
// Controller: accepts a word, sequences the set read, the commit and the
// clearing sweep.
// ----------------------------------------------------------------------------
module bpht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bpht_pkg::dp_stat_t  stat_i,
  output bpht_pkg::dp_ctrl_t  ctrl_o
);
  import bpht_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_CLR  = 2'd2;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d           = state_q;
    ctrl_o            = '0;
    in_ready_o        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d = stat_i.is_clear ? ST_CLR : ST_IDLE;
        end
      end
      ST_CLR: begin
        ctrl_o.clear_step = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register, sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/bpht_dp.sv =====
// ----------------------------------------------------------------------------
// bpht_dp
// Datapath: set memory, way match and replacement, score adjustment,
// age and threshold registers, result register.
// ----------------------------------------------------------------------------
module bpht_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpht_pkg::dp_ctrl_t  ctrl_i,
  output bpht_pkg::dp_stat_t  stat_o,
  input  logic [2:0]          cmd_i,
  input  logic [63:0]         key_i,
  input  logic signed [7:0]   depth_i,
  input  logic signed [15:0]  value_i,
  input  logic [1:0]          bound_i,
  input  logic [31:0]         move_i,
  input  logic [6:0]          ply_i,
  input  logic signed [15:0]  alpha_i,
  input  logic signed [15:0]  beta_i,
  input  logic                cfg_we_i,
  input  logic [14:0]         cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                success_o,
  output logic                matched_o,
  output logic signed [15:0]  value_o,
  output logic [31:0]         move_o
);
  import bpht_pkg::*;

  // set memory
  row_t mem [NUM_SETS];
  row_t rdata_q;
  row_t wrow;
  logic                we;
  logic [SET_BITS-1:0] waddr;
  row_t                wdata;

  // captured word
  logic [2:0]         cmd_q;
  logic [31:0]        tag_q;
  logic [SET_BITS-1:0] set_q;
  logic signed [7:0]  depth_q;
  logic signed [15:0] value_q;
  logic [1:0]         bound_q;
  logic [31:0]        move_q;
  logic [6:0]         ply_q;
  logic signed [15:0] alpha_q;
  logic signed [15:0] beta_q;

  logic [15:0]         age_q;
  logic [14:0]         thr_q;
  logic [SET_BITS-1:0] clr_q;

  logic                out_valid_q;
  logic                succ_q, match_q;
  logic signed [15:0]  val_q;
  logic [31:0]         mv_q;

  // combinational results
  logic               hit;
  logic [WAY_W-1:0]   hit_idx;
  logic [WAY_W-1:0]   slot;
  logic               r_succ;
  logic               r_match;
  logic signed [15:0] r_val;
  logic [31:0]        r_mv;
  logic               wr_need;

  // memory port
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (ctrl_i.capture) rdata_q <= mem[key_i[SET_BITS-1:0]];
  end

  // capture the accepted word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= cmd_i;
      tag_q   <= key_i[31:0];
      set_q   <= key_i[SET_BITS-1:0];
      depth_q <= depth_i;
      value_q <= value_i;
      bound_q <= bound_i;
      move_q  <= move_i;
      ply_q   <= ply_i;
      alpha_q <= alpha_i;
      beta_q  <= beta_i;
    end
  end

  // command evaluation on the read set
  always_comb begin
    logic signed [8:0]  best_aged, best_any, d;
    logic               aged_f, any_f, sfound;
    logic [WAY_W-1:0]   aged_w, any_w;
    logic signed [17:0] thr, plyx, s, v;
    way_t               hv, nw;
    hit       = 1'b0;
    hit_idx   = '0;
    best_aged = 9'(DEPTH_LIMIT + 1);
    best_any  = 9'(DEPTH_LIMIT + 1);
    d         = '0;
    v         = '0;
    aged_f    = 1'b0;
    any_f     = 1'b0;
    aged_w    = '0;
    any_w     = '0;
    sfound    = 1'b0;
    thr       = {3'b000, thr_q};
    plyx      = {11'd0, ply_q};
    r_succ    = 1'b0;
    r_match   = 1'b0;
    r_val     = '0;
    r_mv      = '0;
    wrow      = rdata_q;
    wr_need   = 1'b0;
    slot      = '0;

    // first matching way
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && rdata_q[w].tag == tag_q) begin
        hit     = 1'b1;
        hit_idx = WAY_W'(w);
      end
    end
    hv = rdata_q[hit_idx];

    // victim choice for a save
    for (int w = 0; w < WAYS; w++) begin
      d = {rdata_q[w].dep[7], rdata_q[w].dep};
      if (rdata_q[w].age != age_q && d < best_aged) begin
        aged_f = 1'b1; aged_w = WAY_W'(w); best_aged = d;
      end
      if (d < best_any) begin
        any_f = 1'b1; any_w = WAY_W'(w); best_any = d;
      end
    end

    // new record for a save
    s = {{2{value_q[15]}}, value_q};
    s = 18'(sat16(s));
    if (s > thr) s = 18'(sat16(s + plyx));
    else if (s < -thr) s = 18'(sat16(s - plyx));
    nw.tag = tag_q;
    nw.mv  = (hit && move_q == 32'd0) ? hv.mv : move_q;
    nw.val = s[15:0];
    nw.age = age_q;
    nw.dep = depth_q;
    nw.bnd = bound_q;

    unique case (cmd_q)
      CMD_SAVE: begin
        r_match = hit;
        if (hit) slot = hit_idx;
        else if (aged_f) slot = aged_w;
        else if (any_f) slot = any_w;
        else slot = '0;
        wrow[slot] = nw;
        wr_need    = 1'b1;
      end
      CMD_PROBE: begin
        r_match = hit;
        if (hit) begin
          r_mv = hv.mv;
          v = {{2{hv.val[15]}}, hv.val};
          if (hv.dep >= depth_q) begin
            if (v > thr) v = 18'(sat16(v - plyx));
            else if (v < -thr) v = 18'(sat16(v + plyx));
            if ((hv.bnd == BND_UPPER && $signed(v[15:0]) <= alpha_q) ||
                (hv.bnd == BND_LOWER && $signed(v[15:0]) >= beta_q) ||
                hv.bnd == BND_EXACT) begin
              r_succ = 1'b1;
              wrow[hit_idx].age = age_q;
              wr_need = 1'b1;
            end
          end
          r_val = v[15:0];
        end
      end
      CMD_MOVE: begin
        r_match = hit;
        if (hit) r_mv = hv.mv;
      end
      CMD_SING: begin
        r_match = hit;
        for (int w = 0; w < WAYS; w++) begin
          v = {{2{rdata_q[w].val[15]}}, rdata_q[w].val};
          if (!sfound && rdata_q[w].tag == tag_q) begin
            r_val = rdata_q[w].val;
            r_mv  = rdata_q[w].mv;
            if ((rdata_q[w].bnd == BND_LOWER || rdata_q[w].bnd == BND_EXACT) &&
                rdata_q[w].dep >= depth_q && v > -thr && v < thr) begin
              sfound = 1'b1;
            end
          end
        end
        r_succ = sfound;
      end
      default: ;
    endcase
  end

  // write port select: sweep or commit
  always_comb begin
    if (ctrl_i.clear_step) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else begin
      we    = ctrl_i.commit && wr_need;
      waddr = set_q;
      wdata = wrow;
    end
  end

  // age, threshold and sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
      thr_q <= THR_RESET;
      clr_q <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (ctrl_i.commit && cmd_q == CMD_AGE) age_q <= age_q + 16'd1;
      if (ctrl_i.commit && cmd_q == CMD_CLEAR) age_q <= '0;
      if (ctrl_i.clear_step) clr_q <= clr_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      succ_q  <= r_succ;
      match_q <= r_match;
      val_q   <= r_val;
      mv_q    <= r_mv;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.is_clear = (cmd_q == CMD_CLEAR);
  assign stat_o.clr_last = (clr_q == {SET_BITS{1'b1}});

  assign out_valid_o = out_valid_q;
  assign success_o   = succ_q;
  assign matched_o   = match_q;
  assign value_o     = val_q;
  assign move_o      = mv_q;

endmodule

// ===== sv/bucketed_position_hash_table.sv =====
// ----------------------------------------------------------------------------
// bucketed_position_hash_table
// Four-way set-associative table of search records with depth and age
// replacement, driven by save, probe, lookup, query, age and clear commands.
// ----------------------------------------------------------------------------
// For each accepted word the set row is read from the memory into a row
// register at the accept edge; then the result is computed, the modified
// way written back and the result word loaded, unless the result register is
// still full, in which case the commit waits. One word is in work at a time;
// a finished result may wait while the next word is accepted. After reset and
// after each clear command the memory is swept one set per cycle over all
// 16384 sets, during which no word is accepted; mate_threshold writes are
// taken at any time.
// ----------------------------------------------------------------------------
module bucketed_position_hash_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  // fields from bit 0: position_key[63:0], search_depth[71:64],
  // value_in[87:72], bound_kind[89:88], move_in[121:90], ply_count[128:122],
  // alpha_bound[144:129], beta_bound[160:145], zero padding
  input  logic [167:0] s_axis_tdata,
  // fields: cmd[2:0]
  input  logic [2:0]   s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // fields from bit 0: success[0], matched[1], value_out[17:2],
  // move_out[49:18], zero padding
  output logic [55:0]  m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we_i,
  input  logic [14:0]  cfg_wdata_i
);
  import bpht_pkg::*;

  dp_ctrl_t           ctrl;
  dp_stat_t           stat;
  logic               succ, match;
  logic signed [15:0] val;
  logic [31:0]        mv;

  // controller
  bpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // datapath
  bpht_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .cmd_i       (s_axis_tuser),
    .key_i       (s_axis_tdata[63:0]),
    .depth_i     (s_axis_tdata[71:64]),
    .value_i     (s_axis_tdata[87:72]),
    .bound_i     (s_axis_tdata[89:88]),
    .move_i      (s_axis_tdata[121:90]),
    .ply_i       (s_axis_tdata[128:122]),
    .alpha_i     (s_axis_tdata[144:129]),
    .beta_i      (s_axis_tdata[160:145]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .success_o   (succ),
    .matched_o   (match),
    .value_o     (val),
    .move_o      (mv)
  );

  // result word packing
  assign m_axis_tdata = {6'd0, mv, val, match, succ};

endmodule
